>>> design/stm_pkg.sv
// Shared types, constants and helper functions of the sparse-table range-minimum block.
package stm_pkg;

    localparam int POS_W       = 16;
    localparam int LVL_W       = 5;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic {
        ST_RUN,
        ST_BUILD
    } back_state_t;

    // One classified beat travelling from the front to the back.
    typedef struct packed {
        logic              is_query;
        logic              err;
        logic              last;
        logic [LVL_W-1:0]  lvl;
        logic [POS_W-1:0]  pos_a;
        logic [POS_W-1:0]  pos_b;
        logic [31:0]       value;
    } entry_t;

    function automatic logic [31:0] smin(input logic [31:0] a, input logic [31:0] b);
        return ($signed(a) <= $signed(b)) ? a : b;
    endfunction

    // Position of the highest set bit of an 11-bit length.
    function automatic logic [LVL_W-1:0] floor_log2(input logic [10:0] v);
        logic [LVL_W-1:0] k;
        k = '0;
        for (int b = 1; b < 11; b++)
        begin
            if (v[b])
            begin
                k = LVL_W'(b);
            end
        end
        return k;
    endfunction

endpackage

>>> design/stm_front.sv
// Front part: accepts beats, keeps element count and build flag, classifies queries.
module stm_front #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int LEVELS       = 11
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 command,
    input  logic [9:0]           position,
    input  logic [9:0]           right_end,
    input  logic signed [31:0]   element_value,
    input  logic                 last_element,
    input  logic                 q_full,
    output logic                 q_push,
    output stm_pkg::entry_t      q_entry
);

    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    logic [CW-1:0]  count_reg, count_next;
    logic           built_reg, built_next;
    logic           accept, is_query, load_ok, err;
    logic [10:0]    len, posb;
    logic [stm_pkg::LVL_W-1:0] k_raw, k_sat;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign is_query = (command == stm_pkg::CMD_QUERY);
    assign load_ok  = 32'(position) < 32'(MAX_ELEMENTS);
    assign q_push   = accept && (is_query || load_ok);

    assign err = !built_reg || (position > right_end)
                 || (32'(right_end) >= 32'(count_reg))
                 || (32'(right_end) >= 32'(MAX_ELEMENTS));

    assign len   = 11'(right_end) - 11'(position) + 11'd1;
    assign k_raw = stm_pkg::floor_log2(len);
    assign k_sat = (32'(k_raw) > 32'(LEVELS - 1)) ? stm_pkg::LVL_W'(LEVELS - 1) : k_raw;
    assign posb  = 11'(right_end) + 11'd1 - (11'd1 << k_sat);

    always_comb
    begin
        q_entry.is_query = is_query;
        q_entry.err      = err;
        q_entry.last     = last_element;
        q_entry.lvl      = k_sat;
        q_entry.pos_a    = stm_pkg::POS_W'(position);
        q_entry.pos_b    = stm_pkg::POS_W'(posb);
        q_entry.value    = element_value;
    end

    always_comb
    begin
        count_next = count_reg;
        built_next = built_reg;
        if (accept && !is_query && load_ok)
        begin
            if (last_element)
            begin
                count_next = CW'(32'(position) + 32'd1);
                built_next = 1'b1;
            end
            else
            begin
                built_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            built_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            built_reg <= built_next;
        end
    end

endmodule

>>> design/stm_queue.sv
// Short queue of classified beats between the front and the back.
module stm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  stm_pkg::entry_t  push_entry,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output stm_pkg::entry_t  head_entry
);

    localparam int PW = $clog2(stm_pkg::QUEUE_DEPTH);

    stm_pkg::entry_t slots_reg [0:stm_pkg::QUEUE_DEPTH-1];
    logic [PW-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [PW:0]     cnt_reg, cnt_next;

    assign full       = (cnt_reg == (PW+1)'(stm_pkg::QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_entry = slots_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> design/stm_back.sv
// Back part: sparse table memory, level build sequencer and query read pipeline.
module stm_back #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int LEVELS       = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  stm_pkg::entry_t     head_entry,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  range_min,
    output logic                query_error
);

    localparam int AW    = $clog2(MAX_ELEMENTS);
    localparam int LW    = $clog2(LEVELS);
    localparam int CW    = $clog2(MAX_ELEMENTS + 1);
    localparam int DEPTH = LEVELS << AW;

    logic [31:0] mem [0:DEPTH-1];

    stm_pkg::back_state_t state_reg, state_next;
    logic [LW-1:0]   lvl_reg, lvl_next;
    logic [AW-1:0]   i_reg, i_next;
    logic [CW-1:0]   n_reg, n_next;
    logic            wb_valid_reg, wb_valid_next;
    logic [LW+AW-1:0] wb_addr_reg, wb_addr_next;
    logic            r1_valid_reg, r1_valid_next, r1_err_reg, r1_err_next;
    logic            out_valid_reg;
    logic [31:0]     range_min_reg, rd_a_reg, rd_b_reg, min_ab;
    logic            query_error_reg;

    logic            rd_en, we, r1_adv, issue_ok, build_go, build_end, more;
    logic [LW+AW-1:0] ra, rb, wa;
    logic [31:0]     wd;
    logic [CW:0]     half;

    assign min_ab   = stm_pkg::smin(rd_a_reg, rd_b_reg);
    assign r1_adv   = r1_valid_reg && (!out_valid_reg || out_ready);
    assign issue_ok = !r1_valid_reg || r1_adv;
    assign half     = (CW+1)'(1) << (lvl_reg - 1'b1);
    assign more     = ((CW+1)'(i_reg) + half) < (CW+1)'(n_reg);
    assign build_end = (state_reg == stm_pkg::ST_BUILD) && !more
                       && (32'(lvl_reg) == LEVELS - 1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stm_pkg::ST_RUN:
            begin
                if (build_go)
                begin
                    state_next = stm_pkg::ST_BUILD;
                end
            end
            stm_pkg::ST_BUILD:
            begin
                if (build_end)
                begin
                    state_next = stm_pkg::ST_RUN;
                end
            end
            default: state_next = stm_pkg::ST_RUN;
        endcase
    end

    // Datapath control.
    always_comb
    begin
        pop           = 1'b0;
        rd_en         = 1'b0;
        we            = 1'b0;
        build_go      = 1'b0;
        ra            = {LW'(head_entry.lvl), AW'(head_entry.pos_a)};
        rb            = {LW'(head_entry.lvl), AW'(head_entry.pos_b)};
        wa            = {LW'(0), AW'(head_entry.pos_a)};
        wd            = head_entry.value;
        lvl_next      = lvl_reg;
        i_next        = i_reg;
        n_next        = n_reg;
        wb_valid_next = 1'b0;
        wb_addr_next  = wb_addr_reg;
        r1_valid_next = r1_adv ? 1'b0 : r1_valid_reg;
        r1_err_next   = r1_err_reg;
        case (state_reg)
            stm_pkg::ST_RUN:
            begin
                if (head_valid)
                begin
                    if (head_entry.is_query)
                    begin
                        pop = issue_ok;
                        rd_en = issue_ok && !head_entry.err;
                        if (issue_ok)
                        begin
                            r1_valid_next = 1'b1;
                            r1_err_next   = head_entry.err;
                        end
                    end
                    else if (!head_entry.last)
                    begin
                        pop = 1'b1;
                        we  = 1'b1;
                    end
                    else
                    begin
                        // The build shares the read ports, so wait for the query stage.
                        pop      = !r1_valid_reg;
                        we       = !r1_valid_reg;
                        build_go = !r1_valid_reg;
                        lvl_next = LW'(1);
                        i_next   = '0;
                        n_next   = CW'(32'(head_entry.pos_a) + 32'd1);
                    end
                end
            end
            stm_pkg::ST_BUILD:
            begin
                ra = {lvl_reg - 1'b1, i_reg};
                rb = {lvl_reg - 1'b1, AW'((CW+1)'(i_reg) + half)};
                wa = wb_addr_reg;
                wd = min_ab;
                we = wb_valid_reg;
                if (more)
                begin
                    rd_en         = 1'b1;
                    wb_valid_next = 1'b1;
                    wb_addr_next  = {lvl_reg, i_reg};
                    i_next        = i_reg + 1'b1;
                end
                else
                begin
                    // This idle read slot lets the last write of a level land.
                    i_next   = '0;
                    lvl_next = lvl_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[ra];
            rd_b_reg <= mem[rb];
        end
        if (r1_adv)
        begin
            range_min_reg   <= r1_err_reg ? 32'd0 : min_ab;
            query_error_reg <= r1_err_reg;
        end
        lvl_reg     <= lvl_next;
        i_reg       <= i_next;
        n_reg       <= n_next;
        wb_addr_reg <= wb_addr_next;
        r1_err_reg  <= r1_err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stm_pkg::ST_RUN;
            wb_valid_reg  <= 1'b0;
            r1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wb_valid_reg  <= wb_valid_next;
            r1_valid_reg  <= r1_valid_next;
            if (r1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign range_min   = range_min_reg;
    assign query_error = query_error_reg;

    a_no_pop_in_build: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == stm_pkg::ST_BUILD |-> !pop)
        else $error("queue popped during build");
    a_no_query_in_build: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == stm_pkg::ST_BUILD |-> !r1_valid_reg)
        else $error("query read pending during build");
    a_wb_only_in_build: assert property (@(posedge clk) disable iff (!rst_n)
        wb_valid_reg |-> state_reg == stm_pkg::ST_BUILD)
        else $error("level write outside build");
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && query_error_reg |-> range_min_reg == 32'd0)
        else $error("error result carries nonzero minimum");

endmodule

>>> design/sparse_table_range_minimum_top.sv
// Top level of the sparse-table range-minimum engine.
// Usage: one input channel (in_valid/in_ready) carries load and query beats;
// one output channel (out_valid/out_ready) returns one beat per query and
// nothing for loads. A load writes element_value at position; the load marked
// last_element sets the element count and starts the build of all levels.
// A query gives the minimum over [position, right_end], or query_error with a
// zero minimum when the range is inverted, beyond the count, or not built.
// With nothing ahead of it, a query passes the queue, the table read and the result
// register before its out_valid rises. Throughput: one beat per cycle for loads and
// queries while no build runs and the receiver keeps up, limited by the two read
// ports and one write port of the table memory. A build fills each level j from 1
// to LEVELS-1 with its (count - 2^(j-1)) entries where that is positive, then leaves
// an idle read slot; beats keep queuing meanwhile until the four-entry queue fills,
// then in_ready drops. Reset clears the count and build flag; the table itself is
// not cleared. When the receiver stalls, the result register holds, the query stage
// behind it holds, and input stops once the queue is full.
module sparse_table_range_minimum_top #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int LEVELS       = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                command,
    input  logic [9:0]          position,
    input  logic [9:0]          right_end,
    input  logic signed [31:0]  element_value,
    input  logic                last_element,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  range_min,
    output logic                query_error
);

    logic            q_full, q_push, q_pop, head_valid;
    stm_pkg::entry_t push_entry, head_entry;

    stm_front #(.MAX_ELEMENTS(MAX_ELEMENTS), .LEVELS(LEVELS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .position(position), .right_end(right_end),
        .element_value(element_value), .last_element(last_element),
        .q_full(q_full), .q_push(q_push), .q_entry(push_entry)
    );

    stm_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(q_push), .push_entry(push_entry), .full(q_full),
        .pop(q_pop), .head_valid(head_valid), .head_entry(head_entry)
    );

    stm_back #(.MAX_ELEMENTS(MAX_ELEMENTS), .LEVELS(LEVELS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .head_valid(head_valid), .head_entry(head_entry), .pop(q_pop),
        .out_valid(out_valid), .out_ready(out_ready),
        .range_min(range_min), .query_error(query_error)
    );

endmodule

>>> test/tb_top.sv
// Testbench for the sparse-table range-minimum engine: directed and random loads and queries.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // The idle limit must outlast a build of the whole table, during which no beat
    // moves once the queue has filled.
    localparam int IDLE_LIMIT = 60000;
    localparam int N_ELEM     = 1024;
    localparam int TAIL_WAIT  = 20;

    typedef struct {
        logic signed [31:0] min_val;
        logic               err;
    } min_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               command;
    logic [9:0]         position;
    logic [9:0]         right_end;
    logic signed [31:0] element_value;
    logic               last_element;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] range_min;
    logic               query_error;

    // Predictor state: level 0 of the table, which entries were ever written,
    // the element count and whether the levels are currently built.
    logic signed [31:0] elem_store [N_ELEM];
    bit                 elem_written [N_ELEM];
    int                 written_prefix;
    int                 elem_count;
    bit                 levels_built;

    min_result_t        pending_mins [$];

    int  error_count;
    int  load_beats;
    int  query_beats;
    int  results_seen;
    int  error_results;
    int  idle_cycles;
    bit  send_burst;
    bit  recv_burst;

    sparse_table_range_minimum_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .position      (position),
        .right_end     (right_end),
        .element_value (element_value),
        .last_element  (last_element),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .range_min     (range_min),
        .query_error   (query_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Apply one accepted beat to the predictor. A query pushes the minimum it
    // expects, computed directly over level 0; a built sparse table gives the
    // same answer because every non-last load clears the built flag.
    function automatic void track_beat(input stm_pkg::cmd_t cmd, input int left,
                                       input int right,
                                       input logic signed [31:0] value, input bit last);
        min_result_t res;
        if (cmd == stm_pkg::CMD_LOAD)
        begin
            load_beats++;
            elem_store[left]   = value;
            elem_written[left] = 1'b1;
            while (written_prefix < N_ELEM && elem_written[written_prefix])
            begin
                written_prefix++;
            end
            if (last)
            begin
                elem_count   = left + 1;
                levels_built = 1'b1;
            end
            else
            begin
                levels_built = 1'b0;
            end
        end
        else
        begin
            query_beats++;
            if (!levels_built || left > right || right >= elem_count)
            begin
                res.min_val = '0;
                res.err     = 1'b1;
            end
            else
            begin
                res.min_val = elem_store[left];
                for (int i = left + 1; i <= right; i++)
                begin
                    if (elem_store[i] < res.min_val)
                    begin
                        res.min_val = elem_store[i];
                    end
                end
                res.err = 1'b0;
            end
            pending_mins.push_back(res);
        end
    endfunction

    // Send one beat: an optional random gap, then hold valid until accepted.
    task automatic send_beat(input stm_pkg::cmd_t cmd, input int left, input int right,
                             input logic signed [31:0] value, input bit last);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        command       <= cmd;
        position      <= left[9:0];
        right_end     <= right[9:0];
        element_value <= value;
        last_element  <= last;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        track_beat(cmd, left, right, value, last);
    endtask

    // Values lean toward the signed extremes so ties and sign handling get hit.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            4:       return $signed(32'($urandom_range(0, 15)));
            default: return $signed($urandom);
        endcase
    endfunction

    task automatic load_beat(input int pos, input bit last);
        send_beat(stm_pkg::CMD_LOAD, pos, $urandom_range(0, 1023), pick_value(), last);
    endtask

    task automatic query_beat(input int left, input int right);
        // element_value and last_element are don't-care for queries, so they toggle freely.
        send_beat(stm_pkg::CMD_QUERY, left, right, $signed($urandom), $urandom_range(0, 1));
    endtask

    // Mostly well-formed queries inside the built range; the rest are random
    // ranges that often land inverted or beyond the count.
    task automatic random_query();
        int l;
        int r;
        if (elem_count > 0 && $urandom_range(0, 9) < 8)
        begin
            l = $urandom_range(0, elem_count - 1);
            r = $urandom_range(l, elem_count - 1);
        end
        else
        begin
            l = $urandom_range(0, 1023);
            r = $urandom_range(0, 1023);
        end
        query_beat(l, r);
    endtask

    task automatic wait_drained();
        while (pending_mins.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Directed corner cases: query before any build, signed extremes,
    // single-element and full ranges, inverted and out-of-count ranges,
    // and a load after a build that must invalidate the table.
    task automatic test_directed();
        send_burst = 1'b0;
        query_beat(0, 0);
        send_beat(stm_pkg::CMD_LOAD, 0, 0, 32'sh8000_0000, 1'b0);
        send_beat(stm_pkg::CMD_LOAD, 1, 0, 32'sh7fff_ffff, 1'b0);
        send_beat(stm_pkg::CMD_LOAD, 2, 0, 32'sh0000_0000, 1'b0);
        send_beat(stm_pkg::CMD_LOAD, 3, 0, -32'sd1, 1'b0);
        send_beat(stm_pkg::CMD_LOAD, 4, 0, 32'sd5, 1'b1);
        query_beat(0, 4);
        query_beat(1, 1);
        query_beat(1, 2);
        query_beat(3, 4);
        query_beat(2, 1);
        query_beat(0, 5);
        query_beat(1023, 1023);
        query_beat(0, 1023);
        send_beat(stm_pkg::CMD_LOAD, 2, 0, 32'sd7, 1'b0);
        query_beat(0, 0);
        send_beat(stm_pkg::CMD_LOAD, 4, 0, 32'sd9, 1'b1);
        query_beat(1, 4);
        query_beat(4, 4);
    endtask

    // Fill the whole table, last at the top position, then query across it.
    task automatic test_full_table();
        for (int i = 0; i < N_ELEM; i++)
        begin
            if (i % 128 == 0)
            begin
                send_burst = $urandom_range(0, 1);
            end
            load_beat(i, i == N_ELEM - 1);
        end
        query_beat(0, N_ELEM - 1);
        query_beat(N_ELEM - 1, N_ELEM - 1);
        for (int q = 0; q < 40; q++)
        begin
            random_query();
        end
    endtask

    // Small sets of random size with queries behind each build, plus noise:
    // stray loads that invalidate the table and rebuilds at random positions.
    task automatic test_random_sets();
        int n;
        for (int s = 0; s < 5; s++)
        begin
            send_burst = ($urandom_range(0, 3) == 0);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 300) : $urandom_range(1, 24);
            for (int i = 0; i < n; i++)
            begin
                load_beat(i, i == n - 1);
            end
            for (int q = $urandom_range(3, 15); q > 0; q--)
            begin
                random_query();
            end
            if ($urandom_range(0, 3) == 0)
            begin
                load_beat($urandom_range(0, 1023), 1'b0);
                random_query();
                // Every entry was written by the full-table pass, so any last position is safe.
                if (written_prefix == N_ELEM)
                begin
                    load_beat($urandom_range(0, 1023), 1'b1);
                    random_query();
                end
            end
        end
    endtask

    // The sender holds off until every outstanding result is back, then
    // fires a burst of queries into the empty pipeline.
    task automatic test_drain_pause();
        for (int r = 0; r < 3; r++)
        begin
            in_valid <= 1'b0;
            wait_drained();
            send_burst = 1'b1;
            for (int q = 0; q < 12; q++)
            begin
                random_query();
            end
        end
    endtask

    // Result side: random stall before each beat, with stretches of none.
    initial
    begin
        int gap;
        min_result_t exp_res;
        out_ready  = 1'b0;
        recv_burst = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                recv_burst = ~recv_burst;
            end
            gap = recv_burst ? 0 : $urandom_range(0, 16);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!out_valid);
            results_seen++;
            if (pending_mins.size() == 0)
            begin
                error_count++;
                $display("%0t: result with nothing expected: min %0d err %0b",
                         $time, range_min, query_error);
            end
            else
            begin
                exp_res = pending_mins.pop_front();
                if (exp_res.err)
                begin
                    error_results++;
                end
                if (range_min !== exp_res.min_val)
                begin
                    error_count++;
                    $display("%0t: range_min expected %0d actual %0d",
                             $time, exp_res.min_val, range_min);
                end
                if (query_error !== exp_res.err)
                begin
                    error_count++;
                    $display("%0t: query_error expected %0b actual %0b",
                             $time, exp_res.err, query_error);
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_top: errors");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        command        = stm_pkg::CMD_LOAD;
        position       = '0;
        right_end      = '0;
        element_value  = '0;
        last_element   = 1'b0;
        written_prefix = 0;
        elem_count     = 0;
        levels_built   = 1'b0;
        error_count    = 0;
        load_beats     = 0;
        query_beats    = 0;
        results_seen   = 0;
        error_results  = 0;
        idle_cycles    = 0;
        send_burst     = 1'b0;
        for (int i = 0; i < N_ELEM; i++)
        begin
            elem_written[i] = 1'b0;
            elem_store[i]   = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_table();
        test_random_sets();
        test_drain_pause();

        in_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_WAIT) @(posedge clk);

        $display("Covered %0d load beats and %0d query beats, up to a full table build.",
                 load_beats, query_beats);
        $display("Checked %0d results, %0d of them flagged as query errors.",
                 results_seen, error_results);
        if (error_count == 0 && pending_mins.size() == 0)
        begin
            $display("tb_top: clean");
        end
        else
        begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
